@@ hdl/ssce_pkg.sv @@
// ssce_pkg: shared constants, codes and crc7 helpers for the sd spi command engine
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps

package ssce_pkg;

	// field widths
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned ARG_W    = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned RLIM_W   = 14;
	localparam int unsigned TLIM_W   = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W    = 14;
	localparam int unsigned CRC_W    = 7;
	localparam int unsigned CRC_MSG_W = INDEX_W + 2 + ARG_W;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ABORT = 2'd2;

	// request modes
	localparam logic MODE_ISSUE = 1'b0;
	localparam logic MODE_BYTE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_READY_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_LIMIT  = 1'd1;

	// reset values of the limits
	localparam logic [RLIM_W-1:0] READY_LIMIT_RST = 14'd16000;
	localparam logic [TLIM_W-1:0] RESP_LIMIT_RST  = 8'd253;

	// protocol constants
	localparam logic [BYTE_W-1:0]  BYTE_IDLE  = 8'hFF;
	localparam logic [1:0]         START_BITS = 2'b01;
	localparam logic [INDEX_W-1:0] STOP_INDEX = 6'd12;

	// crc7 (x^7+x^3+1) of a message, msb first, zero start
	function automatic logic [CRC_W-1:0] crc7_calc(input logic [CRC_MSG_W-1:0] msg);
		logic [CRC_W:0] crc;
		crc = '0;
		for (int k = CRC_MSG_W - 1; k >= 0; k--) begin
			crc = {crc[CRC_W-1:0], 1'b0};
			if (msg[k] ^ crc[CRC_W])
				crc = crc ^ 8'h09;
		end
		return crc[CRC_W-1:0];
	endfunction

	// crc contribution of each single message bit; the crc is linear
	function automatic logic [CRC_MSG_W*CRC_W-1:0] crc7_cols();
		logic [CRC_MSG_W*CRC_W-1:0] tbl;
		tbl = '0;
		for (int i = 0; i < CRC_MSG_W; i++)
			tbl[i*CRC_W +: CRC_W] = crc7_calc(CRC_MSG_W'(1) << i);
		return tbl;
	endfunction

	localparam logic [CRC_MSG_W*CRC_W-1:0] CRC7_COLS = crc7_cols();

endpackage

@@ hdl/ssce_if.sv @@
// ssce_req_if and ssce_rsp_if: valid/ready channels of the sd spi command engine
// depends on ssce_pkg for field widths
`timescale 1ns / 1ps

interface ssce_req_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [ssce_pkg::INDEX_W-1:0]     cmd_index;
	logic [ssce_pkg::ARG_W-1:0]       argument;
	logic [ssce_pkg::BYTE_W-1:0]      rx_byte;

	modport source (output valid, mode, cmd_index, argument, rx_byte, input ready);
	modport sink   (input valid, mode, cmd_index, argument, rx_byte, output ready);
endinterface

interface ssce_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ssce_pkg::KIND_W-1:0]      kind;
	logic [ssce_pkg::BYTE_W-1:0]      data_byte;
	logic                             last;
	logic                             timed_out;
	logic                             is_r1;
	logic                             in_idle;
	logic                             erase_reset;
	logic                             illegal_command;
	logic                             crc_error;
	logic                             erase_sequence_error;
	logic                             address_error;
	logic                             parameter_error;

	modport source (output valid, kind, data_byte, last, timed_out, is_r1, in_idle,
		erase_reset, illegal_command, crc_error, erase_sequence_error, address_error,
		parameter_error, input ready);
	modport sink   (input valid, kind, data_byte, last, timed_out, is_r1, in_idle,
		erase_reset, illegal_command, crc_error, erase_sequence_error, address_error,
		parameter_error, output ready);
endinterface

@@ hdl/sd_spi_command_engine.sv @@
// sd_spi_command_engine: a request waits in the input stage until the result buffer has
// room, is then processed, and its first result is registered in the result buffer.
// a ready byte yields six frame bytes, one per cycle while rsp.ready is high; while they
// drain, the input stage holds the next request. throughput otherwise one request/cycle
// while rsp.ready is high. arst_n (async, active low) clears to idle, limits 16000
// and 253, held command zero. depends on ssce_pkg and ssce_if
`timescale 1ns / 1ps

module sd_spi_command_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ssce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssce_pkg::CFG_W-1:0]        cfg_data,
	ssce_req_if.sink                          req,
	ssce_rsp_if.source                        rsp
);

	// phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_READY = 2'd1;
	localparam logic [1:0] PH_STUFF = 2'd2;
	localparam logic [1:0] PH_RESP  = 2'd3;

	localparam int unsigned FRAME_LEN  = 6;
	localparam int unsigned CNT_W      = 3;
	localparam int unsigned REST_W     = (FRAME_LEN - 1) * ssce_pkg::BYTE_W;
	localparam int unsigned R1_FLAGS_W = 7;

	typedef struct packed {
		logic [ssce_pkg::KIND_W-1:0] kind;
		logic [ssce_pkg::BYTE_W-1:0] data_byte;
		logic                        last;
		logic                        timed_out;
		logic                        is_r1;
		logic [R1_FLAGS_W-1:0]       flags;
	} res_t;

	// configuration registers
	logic [ssce_pkg::RLIM_W-1:0] ready_limit_q;
	logic [ssce_pkg::TLIM_W-1:0] response_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_limit_q    <= ssce_pkg::READY_LIMIT_RST;
			response_limit_q <= ssce_pkg::RESP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssce_pkg::REG_READY_LIMIT: ready_limit_q <= cfg_data;
				ssce_pkg::REG_RESP_LIMIT:  response_limit_q <= cfg_data[ssce_pkg::TLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic                           v_s1;
	logic                           mode_s1;
	logic [ssce_pkg::INDEX_W-1:0]   idx_s1;
	logic [ssce_pkg::ARG_W-1:0]     arg_s1;
	logic [ssce_pkg::BYTE_W-1:0]    rx_s1;

	// result buffer
	res_t               res_q;
	logic [REST_W-1:0]  rest_q;
	logic [CNT_W-1:0]   cnt_q;

	logic buf_room;
	logic go;
	logic pop;

	assign pop      = (cnt_q != '0) && rsp.ready;
	assign buf_room = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && rsp.ready);
	assign go       = v_s1 && buf_room;
	assign req.ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (req.ready)
			v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			mode_s1 <= req.mode;
			idx_s1  <= req.cmd_index;
			arg_s1  <= req.argument;
			rx_s1   <= req.rx_byte;
		end
	end

	// engine state
	logic [1:0]                   phase_q;
	logic [ssce_pkg::INDEX_W-1:0] held_index_q;
	logic [ssce_pkg::ARG_W-1:0]   held_argument_q;
	logic [ssce_pkg::RLIM_W-1:0]  wait_count_q;

	// frame and crc from the held command
	logic [ssce_pkg::CRC_MSG_W-1:0] msg;
	logic [ssce_pkg::CRC_W-1:0]     crc;

	always_comb begin
		msg = {ssce_pkg::START_BITS, held_index_q, held_argument_q};
		crc = '0;
		for (int i = 0; i < ssce_pkg::CRC_MSG_W; i++)
			if (msg[i])
				crc = crc ^ ssce_pkg::CRC7_COLS[i*ssce_pkg::CRC_W +: ssce_pkg::CRC_W];
	end

	// next state and result of the request in the input stage
	logic [1:0]                   phase_d;
	logic [ssce_pkg::RLIM_W-1:0]  wait_d;
	logic                         emit;
	logic                         emit_frame;
	res_t                         res_d;
	logic                         rx_idle;

	assign rx_idle = (rx_s1 == ssce_pkg::BYTE_IDLE);

	always_comb begin
		phase_d    = phase_q;
		wait_d     = wait_count_q;
		emit       = 1'b0;
		emit_frame = 1'b0;
		res_d      = '{kind: ssce_pkg::KIND_FRAME, data_byte: msg[ssce_pkg::CRC_MSG_W-1 -:
			ssce_pkg::BYTE_W], last: 1'b0, timed_out: 1'b0, is_r1: 1'b0, flags: '0};
		if (mode_s1 == ssce_pkg::MODE_ISSUE) begin
			phase_d = PH_READY;
			wait_d  = '0;
		end else begin
			unique case (phase_q)
				PH_READY: begin
					if (rx_idle) begin
						emit       = 1'b1;
						emit_frame = 1'b1;
						wait_d     = '0;
						phase_d    = (held_index_q == ssce_pkg::STOP_INDEX) ? PH_STUFF : PH_RESP;
					end else if (wait_count_q >= ready_limit_q) begin
						emit            = 1'b1;
						res_d.kind      = ssce_pkg::KIND_ABORT;
						res_d.data_byte = ssce_pkg::BYTE_IDLE;
						res_d.last      = 1'b1;
						phase_d         = PH_IDLE;
						wait_d          = '0;
					end else begin
						wait_d = wait_count_q + 1'b1;
					end
				end
				PH_STUFF: begin
					phase_d = PH_RESP;
					wait_d  = '0;
				end
				PH_RESP: begin
					if (wait_count_q > {{(ssce_pkg::RLIM_W - ssce_pkg::TLIM_W){1'b0}},
						response_limit_q}) begin
						emit            = 1'b1;
						res_d.kind      = ssce_pkg::KIND_RESP;
						res_d.data_byte = ssce_pkg::BYTE_IDLE;
						res_d.last      = 1'b1;
						res_d.timed_out = 1'b1;
						phase_d         = PH_IDLE;
						wait_d          = '0;
					end else if (!rx_idle) begin
						emit            = 1'b1;
						res_d.kind      = ssce_pkg::KIND_RESP;
						res_d.data_byte = rx_s1;
						res_d.last      = 1'b1;
						res_d.is_r1     = !rx_s1[ssce_pkg::BYTE_W-1];
						res_d.flags     = rx_s1[ssce_pkg::BYTE_W-1] ? '0 : rx_s1[R1_FLAGS_W-1:0];
						phase_d         = PH_IDLE;
						wait_d          = '0;
					end else begin
						wait_d = wait_count_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			held_index_q    <= '0;
			held_argument_q <= '0;
			wait_count_q    <= '0;
		end else if (go) begin
			phase_q      <= phase_d;
			wait_count_q <= wait_d;
			if (mode_s1 == ssce_pkg::MODE_ISSUE) begin
				held_index_q    <= idx_s1;
				held_argument_q <= arg_s1;
			end
		end
	end

	// result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (go && emit)
			cnt_q <= emit_frame ? CNT_W'(FRAME_LEN) : CNT_W'(1);
		else if (pop)
			cnt_q <= cnt_q - 1'b1;
	end

	// result payload; frame tail shifts out one byte per result taken
	always_ff @(posedge clk) begin
		if (go && emit) begin
			res_q  <= res_d;
			rest_q <= {msg[ssce_pkg::ARG_W-1:0], crc, 1'b1};
		end else if (pop && (cnt_q > CNT_W'(1))) begin
			res_q.data_byte <= rest_q[REST_W-1 -: ssce_pkg::BYTE_W];
			res_q.last      <= (cnt_q == CNT_W'(2));
			rest_q          <= {rest_q[REST_W-ssce_pkg::BYTE_W-1:0], {ssce_pkg::BYTE_W{1'b0}}};
		end
	end

	// result channel
	assign rsp.valid                = (cnt_q != '0);
	assign rsp.kind                 = res_q.kind;
	assign rsp.data_byte            = res_q.data_byte;
	assign rsp.last                 = res_q.last;
	assign rsp.timed_out            = res_q.timed_out;
	assign rsp.is_r1                = res_q.is_r1;
	assign rsp.in_idle              = res_q.flags[0];
	assign rsp.erase_reset          = res_q.flags[1];
	assign rsp.illegal_command      = res_q.flags[2];
	assign rsp.crc_error            = res_q.flags[3];
	assign rsp.erase_sequence_error = res_q.flags[4];
	assign rsp.address_error        = res_q.flags[5];
	assign rsp.parameter_error      = res_q.flags[6];

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRAME_LEN))
		else $error("result buffer count out of range");

	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (res_q.kind == ssce_pkg::KIND_FRAME)) |->
		(res_q.last == (cnt_q == CNT_W'(1))))
		else $error("frame last flag out of step with buffer count");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (res_q.kind != ssce_pkg::KIND_FRAME)) |-> (cnt_q == CNT_W'(1)) && res_q.last)
		else $error("response or abort not a single last result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (cnt_q <= CNT_W'(1)))
		else $error("request processed while frame still draining");

	a_stuff_cmd12: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STUFF) |-> (held_index_q == ssce_pkg::STOP_INDEX))
		else $error("stuff byte phase without stop command");

	a_flags_r1: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !res_q.is_r1) |-> (res_q.flags == '0))
		else $error("r1 flags set on a result that is not r1");

endmodule
